// File: design/triangle_unit_normal_core_defines.svh
// ----------------------------------------------------------------------------
// Triangle unit normal core: assertion macros
// Assertion macros used by the core module to check its own behaviour.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_CORE_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TUN_ASSERT_NOW(lbl, clk_s, rst_n, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (cond)) \
	else $error("assertion failed");
`define TUN_ASSERT_IMP(lbl, clk_s, rst_n, pre, post) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
`else
`define TUN_ASSERT_NOW(lbl, clk_s, rst_n, cond)
`define TUN_ASSERT_IMP(lbl, clk_s, rst_n, pre, post)
`endif
`endif

// File: design/tun_pkg.sv
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Widths and the structures that travel between the pipeline sections.
// ----------------------------------------------------------------------------
`default_nettype none
package tun_pkg;
	localparam int CW = 16;
	localparam int DW = 17;
	localparam int PW = 34;
	localparam int XW = 35;
	localparam int MW = 34;
	localparam int HW = 17;
	localparam int SW = 68;
	localparam int WR = 104;
	localparam int VB = 16;
	localparam int QB = 15;

	typedef struct packed {
		logic [2:0][CW-1:0] first;
		logic [2:0][CW-1:0] second;
		logic [2:0][CW-1:0] third;
	} vtx_t;

	typedef struct packed {
		logic [2:0][MW-1:0] mag;
		logic [2:0]         neg;
		logic               degen;
	} mag_t;

	typedef struct packed {
		logic [SW-1:0]      s;
		logic [2:0][WR-1:0] r;
		logic [2:0][WR-1:0] y;
		logic [2:0][VB-1:0] v;
		logic [2:0]         neg;
		logic               degen;
	} root_t;
endpackage
`default_nettype wire

// File: design/tun_cross.sv
// ----------------------------------------------------------------------------
// Triangle unit normal: cross product
// Edge vectors, partial products, exact cross product, magnitudes and signs.
// ----------------------------------------------------------------------------
`default_nettype none
module tun_cross (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vld,
	input  wire tun_pkg::vtx_t vtx,
	output logic               vld_o,
	output tun_pkg::mag_t      mag_o
);
	logic [tun_pkg::DW-1:0] a_s1 [3];
	logic [tun_pkg::DW-1:0] b_s1 [3];
	logic signed [tun_pkg::PW-1:0] p_s2 [6];
	logic [tun_pkg::XW-1:0] c_s3 [3];
	logic [tun_pkg::XW-1:0] nc [3];
	logic v_s1, v_s2, v_s3, v_s4;
	tun_pkg::mag_t m_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nc[i] = ~c_s3[i] + tun_pkg::XW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= {vtx.third[i][tun_pkg::CW-1], vtx.third[i]}
					- {vtx.first[i][tun_pkg::CW-1], vtx.first[i]};
				b_s1[i] <= {vtx.third[i][tun_pkg::CW-1], vtx.third[i]}
					- {vtx.second[i][tun_pkg::CW-1], vtx.second[i]};
			end
			p_s2[0] <= $signed(a_s1[1]) * $signed(b_s1[2]);
			p_s2[1] <= $signed(a_s1[2]) * $signed(b_s1[1]);
			p_s2[2] <= $signed(a_s1[2]) * $signed(b_s1[0]);
			p_s2[3] <= $signed(a_s1[0]) * $signed(b_s1[2]);
			p_s2[4] <= $signed(a_s1[0]) * $signed(b_s1[1]);
			p_s2[5] <= $signed(a_s1[1]) * $signed(b_s1[0]);
			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= {p_s2[2*i][tun_pkg::PW-1], p_s2[2*i]}
					- {p_s2[2*i+1][tun_pkg::PW-1], p_s2[2*i+1]};
			end
			for (int i = 0; i < 3; i++) begin
				m_s4.mag[i] <= c_s3[i][tun_pkg::XW-1] ? nc[i][tun_pkg::MW-1:0]
					: c_s3[i][tun_pkg::MW-1:0];
				m_s4.neg[i] <= c_s3[i][tun_pkg::XW-1];
			end
			m_s4.degen <= (c_s3[0] == '0) && (c_s3[1] == '0) && (c_s3[2] == '0);
		end
	end

	assign vld_o = v_s4;
	assign mag_o = m_s4;
endmodule
`default_nettype wire

// File: design/tun_square.sv
// ----------------------------------------------------------------------------
// Triangle unit normal: squares
// Split squares of the magnitudes, their sum and the start of the root search.
// ----------------------------------------------------------------------------
`default_nettype none
module tun_square (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vld,
	input  wire tun_pkg::mag_t mag,
	output logic               vld_o,
	output tun_pkg::root_t     root_o
);
	logic [2*tun_pkg::HW-1:0] hh_s5 [3];
	logic [2*tun_pkg::HW-1:0] hl_s5 [3];
	logic [2*tun_pkg::HW-1:0] ll_s5 [3];
	logic [2:0] neg_s5, neg_s6;
	logic degen_s5, degen_s6;
	logic [tun_pkg::SW-1:0] sq_s6 [3];
	logic v_s5, v_s6, v_s7;
	tun_pkg::root_t r_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s5 <= vld;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				hh_s5[i] <= mag.mag[i][tun_pkg::MW-1:tun_pkg::HW]
					* mag.mag[i][tun_pkg::MW-1:tun_pkg::HW];
				hl_s5[i] <= mag.mag[i][tun_pkg::MW-1:tun_pkg::HW]
					* mag.mag[i][tun_pkg::HW-1:0];
				ll_s5[i] <= mag.mag[i][tun_pkg::HW-1:0] * mag.mag[i][tun_pkg::HW-1:0];
			end
			neg_s5   <= mag.neg;
			degen_s5 <= mag.degen;
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= {hh_s5[i], 34'd0} + {16'd0, hl_s5[i], 18'd0}
					+ {34'd0, ll_s5[i]};
			end
			neg_s6   <= neg_s5;
			degen_s6 <= degen_s5;
			r_s7.s <= sq_s6[0] + sq_s6[1] + sq_s6[2];
			for (int i = 0; i < 3; i++) begin
				r_s7.r[i] <= {6'd0, sq_s6[i], 30'd0};
				r_s7.y[i] <= '0;
				r_s7.v[i] <= '0;
			end
			r_s7.neg   <= neg_s6;
			r_s7.degen <= degen_s6;
		end
	end

	assign vld_o  = v_s7;
	assign root_o = r_s7;
endmodule
`default_nettype wire

// File: design/tun_root_stage.sv
// ----------------------------------------------------------------------------
// Triangle unit normal: root step
// One bit of the scale factor search for all three components.
// ----------------------------------------------------------------------------
`default_nettype none
module tun_root_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic [3:0]     k,
	input  wire logic           vld,
	input  wire tun_pkg::root_t root,
	output logic                vld_o,
	output tun_pkg::root_t      root_o
);
	logic [tun_pkg::WR-1:0] s_ext;
	logic [tun_pkg::WR-1:0] step [3];
	logic [tun_pkg::WR:0]   diff [3];
	logic [4:0] sh_y, sh_s;
	logic v_q;
	tun_pkg::root_t nx, r_q;

	always_comb begin
		s_ext = tun_pkg::WR'(root.s);
		sh_y  = {1'b0, k} + 5'd1;
		sh_s  = {k, 1'b0};
		nx    = root;
		for (int i = 0; i < 3; i++) begin
			step[i] = (root.y[i] << sh_y) + (s_ext << sh_s);
			diff[i] = {1'b0, root.r[i]} - {1'b0, step[i]};
			if (!diff[i][tun_pkg::WR]) begin
				nx.r[i] = diff[i][tun_pkg::WR-1:0];
				nx.y[i] = root.y[i] + (s_ext << k);
				nx.v[i] = root.v[i] | (tun_pkg::VB'(1) << k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q <= nx;
		end
	end

	assign vld_o  = v_q;
	assign root_o = r_q;
endmodule
`default_nettype wire

// File: design/triangle_unit_normal_core.sv
// ----------------------------------------------------------------------------
// Triangle unit normal core
// Unit face normal of a triangle in Q2.14 from three Q8.8 vertices.
// ----------------------------------------------------------------------------
// The core takes one triangle word in every cycle while in_stall is low.
// Four stages form the exact cross product, three form the sum of squares,
// sixteen resolve one bit each of the exact scale factor, and one rounds,
// signs and holds the result word. A degenerate triangle gives a zero
// vector with the degenerate flag set. The pipeline advances whenever the
// output register is empty or being taken.
`default_nettype none
`include "triangle_unit_normal_core_defines.svh"
module triangle_unit_normal_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic signed [15:0] first_x,
	input  wire logic signed [15:0] first_y,
	input  wire logic signed [15:0] first_z,
	input  wire logic signed [15:0] second_x,
	input  wire logic signed [15:0] second_y,
	input  wire logic signed [15:0] second_z,
	input  wire logic signed [15:0] third_x,
	input  wire logic signed [15:0] third_y,
	input  wire logic signed [15:0] third_z,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic             degenerate
);
	logic en;
	tun_pkg::vtx_t vtx;
	logic mag_vld;
	tun_pkg::mag_t mag;
	logic rv [17];
	tun_pkg::root_t rt [17];
	logic [tun_pkg::QB-1:0] q [3];
	logic [15:0] comp [3];
	logic out_valid_q;
	logic [15:0] nx_q, ny_q, nz_q;
	logic degen_q;

	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	assign vtx.first  = {first_z, first_y, first_x};
	assign vtx.second = {second_z, second_y, second_x};
	assign vtx.third  = {third_z, third_y, third_x};

	tun_cross u_cross (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(in_valid), .vtx(vtx),
		.vld_o(mag_vld), .mag_o(mag)
	);

	tun_square u_square (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(mag_vld), .mag(mag),
		.vld_o(rv[0]), .root_o(rt[0])
	);

	for (genvar g = 0; g < 16; g++) begin : g_root
		tun_root_stage u_stage (
			.clk(clk), .arst_n(arst_n), .en(en), .k(4'(15 - g)),
			.vld(rv[g]), .root(rt[g]), .vld_o(rv[g+1]), .root_o(rt[g+1])
		);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q[i] = tun_pkg::QB'(({1'b0, rt[16].v[i]} + 17'd1) >> 1);
			if (rt[16].degen) begin
				comp[i] = '0;
			end else if (rt[16].neg[i]) begin
				comp[i] = 16'd0 - {1'b0, q[i]};
			end else begin
				comp[i] = {1'b0, q[i]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= rv[16];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_q    <= comp[0];
			ny_q    <= comp[1];
			nz_q    <= comp[2];
			degen_q <= rt[16].degen;
		end
	end

	assign out_valid  = out_valid_q;
	assign normal_x   = nx_q;
	assign normal_y   = ny_q;
	assign normal_z   = nz_q;
	assign degenerate = degen_q;

	`TUN_ASSERT_IMP(a_degen_zero, clk, arst_n, out_valid && degenerate,
		normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0)
	`TUN_ASSERT_IMP(a_normal_nonzero, clk, arst_n, out_valid && !degenerate,
		normal_x != 16'sd0 || normal_y != 16'sd0 || normal_z != 16'sd0)
	`TUN_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)
	`TUN_ASSERT_IMP(a_range_x, clk, arst_n, out_valid,
		normal_x <= 16'sd16384 && normal_x >= -16'sd16384)
endmodule
`default_nettype wire

// File: tb/sv/tb_triangle_unit_normal_core.sv
// ----------------------------------------------------------------------------
// Triangle unit normal core testbench
// Drives triangle words through the core under random idling on both sides,
// predicts each untyped Q2.14 unit normal exactly in wide integers and checks each
// result word in order. A short table of directed words comes first.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_triangle_unit_normal_core;
	typedef struct {
		logic signed [15:0] first_x, first_y, first_z;
		logic signed [15:0] second_x, second_y, second_z;
		logic signed [15:0] third_x, third_y, third_z;
	} tri_t;

	typedef struct {
		logic signed [15:0] nx, ny, nz;
		logic               degen;
	} normal_t;

	typedef struct {
		tri_t    v;
		bit      typed;
		normal_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] first_x = '0, first_y = '0, first_z = '0;
	logic signed [15:0] second_x = '0, second_y = '0, second_z = '0;
	logic signed [15:0] third_x = '0, third_y = '0, third_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic degenerate;

	normal_t pending_normals[$];
	row_t    dir_tbl[$];
	int      mismatches = 0;
	bit      calm = 1'b0;

	triangle_unit_normal_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.first_x(first_x), .first_y(first_y), .first_z(first_z),
		.second_x(second_x), .second_y(second_y), .second_z(second_z),
		.third_x(third_x), .third_y(third_y), .third_z(third_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.degenerate(degenerate)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic signed [15:0] q14_component(longint c, logic [127:0] s);
		longint      m;
		logic [127:0] m2, rhs, odd;
		int          q, cand;
		m = (c < 0) ? -c : c;
		m2 = 128'(m);
		rhs = (m2 * m2) << 30;
		q = 0;
		for (int b = 16384; b != 0; b >>= 1) begin
			cand = q | b;
			if (cand <= 16384) begin
				odd = 128'(2 * cand - 1);
				if (s * odd * odd <= rhs)
					q = cand;
			end
		end
		return 16'((c < 0) ? -q : q);
	endfunction

	function automatic normal_t unit_normal(tri_t t);
		longint      ax, ay, az, bx, by, bz, cx, cy, cz;
		logic [127:0] s, wx, wy, wz;
		normal_t     r;
		ax = t.third_x - t.first_x;
		ay = t.third_y - t.first_y;
		az = t.third_z - t.first_z;
		bx = t.third_x - t.second_x;
		by = t.third_y - t.second_y;
		bz = t.third_z - t.second_z;
		cx = ay * bz - az * by;
		cy = az * bx - ax * bz;
		cz = ax * by - ay * bx;
		if (cx == 0 && cy == 0 && cz == 0) begin
			r = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
			return r;
		end
		wx = 128'((cx < 0) ? -cx : cx);
		wy = 128'((cy < 0) ? -cy : cy);
		wz = 128'((cz < 0) ? -cz : cz);
		s = wx * wx + wy * wy + wz * wz;
		r.nx = q14_component(cx, s);
		r.ny = q14_component(cy, s);
		r.nz = q14_component(cz, s);
		r.degen = 1'b0;
		return r;
	endfunction

	task automatic send_word(tri_t t, bit typed, normal_t want, bit may_idle);
		if (may_idle && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		first_x <= t.first_x;   first_y <= t.first_y;   first_z <= t.first_z;
		second_x <= t.second_x; second_y <= t.second_y; second_z <= t.second_z;
		third_x <= t.third_x;   third_y <= t.third_y;   third_z <= t.third_z;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_normals.push_back(typed ? want : unit_normal(t));
	endtask

	function automatic logic signed [15:0] any_coord(int kind);
		case (kind)
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return 16'($signed($urandom_range(0, 1024)) - 512);
		endcase
	endfunction

	always @(posedge clk) begin
		if (!calm)
			out_stall <= ($urandom_range(99) < 28);
		else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		normal_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_normals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %0d %0d %0d %0b",
						normal_x, normal_y, normal_z, degenerate);
			end else begin
				e = pending_normals.pop_front();
				if (normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz ||
						degenerate !== e.degen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
							e.nx, e.ny, e.nz, e.degen,
							normal_x, normal_y, normal_z, degenerate);
				end
			end
		end
	end

	initial begin
		tri_t    t;
		normal_t none, want;
		int      kind;
		logic signed [15:0] dx, dy, dz;
		none = '{16'sd0, 16'sd0, 16'sd0, 1'b0};
		dir_tbl.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 1}});
		dir_tbl.push_back('{'{-256, 0, 0, 0, -256, 0, 0, 0, 0}, 1,
			'{0, 0, 16384, 0}});
		dir_tbl.push_back('{'{0, -256, 0, 0, 0, -256, 0, 0, 0}, 1,
			'{16384, 0, 0, 0}});
		dir_tbl.push_back('{'{0, 0, -256, -256, 0, 0, 0, 0, 0}, 1,
			'{0, 16384, 0, 0}});
		dir_tbl.push_back('{'{0, -256, 0, -256, 0, 0, 0, 0, 0}, 1,
			'{0, 0, -16384, 0}});
		dir_tbl.push_back('{'{100, 200, 300, 100, 200, 300, 100, 200, 300}, 1,
			'{0, 0, 0, 1}});
		dir_tbl.push_back('{'{0, 0, 0, 10, 20, 30, 20, 40, 60}, 1, '{0, 0, 0, 1}});
		dir_tbl.push_back('{'{-32768, -32768, -32768, 32767, 32767, 32767,
			-32768, -32768, -32768}, 1, '{0, 0, 0, 1}});
		dir_tbl.push_back('{'{-32768, -32768, -32768, 32767, -32768, -32768,
			32767, 32767, 32767}, 0, none});
		dir_tbl.push_back('{'{32767, -32768, 32767, -32768, 32767, -32768,
			-32768, -32768, 32767}, 0, none});
		dir_tbl.push_back('{'{-32768, 32767, 0, 0, -32768, 32767, 32767, 0, -32768},
			0, none});
		dir_tbl.push_back('{'{1, 0, 0, 0, 1, 0, 0, 0, 1}, 0, none});
		dir_tbl.push_back('{'{-1, -1, -1, 0, 0, 0, 1, 2, 4}, 0, none});
		dir_tbl.push_back('{'{256, 0, 0, 0, 256, 0, 0, 0, 257}, 0, none});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tbl[i])
			send_word(dir_tbl[i].v, dir_tbl[i].typed, dir_tbl[i].want, 1'b1);

		for (int n = 0; n < 1250; n++) begin
			if (n == 700) begin
				in_valid <= 1'b0;
				while (pending_normals.size() != 0) @(posedge clk);
			end
			calm = (n >= 400 && n < 650);
			kind = $urandom_range(0, 9);
			t.first_x = any_coord(kind % 3);  t.first_y = any_coord(kind % 3);
			t.first_z = any_coord(kind % 3);  t.second_x = any_coord(kind % 3);
			t.second_y = any_coord(kind % 3); t.second_z = any_coord(kind % 3);
			t.third_x = any_coord(kind % 3);  t.third_y = any_coord(kind % 3);
			t.third_z = any_coord(kind % 3);
			if (kind == 9) begin
				dx = 16'($signed($urandom_range(0, 2000)) - 1000);
				dy = 16'($signed($urandom_range(0, 2000)) - 1000);
				dz = 16'($signed($urandom_range(0, 2000)) - 1000);
				t.first_x = dx; t.first_y = dy; t.first_z = dz;
				t.second_x = 16'(2 * dx); t.second_y = 16'(2 * dy);
				t.second_z = 16'(2 * dz);
				t.third_x = 16'(-3 * dx); t.third_y = 16'(-3 * dy);
				t.third_z = 16'(-3 * dz);
			end
			send_word(t, 1'b0, none, !calm);
		end
		in_valid <= 1'b0;
		calm = 1'b0;
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
